/* design/bpa_pkg.sv */
package bpa_pkg;
    localparam int NUM_PAGES_DEF = 4096;
    localparam int WORD_BITS     = 64;
    localparam int PAGE_SHIFT    = 12;
    localparam int ADDR_PAGES    = 4096;

    typedef enum logic [1:0] {
        REQ_MARK  = 2'd0,
        REQ_ALLOC = 2'd1,
        REQ_FREE  = 2'd2,
        REQ_QUERY = 2'd3
    } t_req;

    // popcount of the free (zero) bits of one word
    function automatic logic [6:0] count_free(input logic [WORD_BITS-1:0] w);
        logic [6:0] c;
        c = '0;
        for (int k = 0; k < WORD_BITS; k++) c = c + {6'd0, ~w[k]};
        return c;
    endfunction
endpackage

/* design/bpa_if.sv */
interface bpa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [23:0] address;
    logic [24:0] region_length;
    logic [12:0] page_count;
    modport source (output valid, req_type, address, region_length, page_count, input ready);
    modport sink   (input valid, req_type, address, region_length, page_count, output ready);
endinterface

interface bpa_rsp_if;
    logic        valid;
    logic        ready;
    logic        success;
    logic [23:0] run_address;
    logic [24:0] free_bytes;
    modport source (output valid, success, run_address, free_bytes, input ready);
    modport sink   (input valid, success, run_address, free_bytes, output ready);
endinterface

/* design/bitmap_page_allocator_top.sv */
// channel   | dir | payload
// i_req     | in  | req_type, address, region_length, page_count
// o_rsp     | out | success, run_address, free_bytes
// i_cfg     | in  | page_limit (13 bits), written whenever i_cfg_we is high
// Bitmap kept in a 1-bit wide memory; one page visited per step.
// Mark clears one page per step (S_RD). Allocate, free, query: each page visited is
// read (S_RD) then tested/written (S_CHK); a found run is then marked used page by page (S_FILL).
// Each word also passes through accept (S_IDLE), result (S_OUT) and turnaround (S_WT).
// After reset: a clearing pass (S_CLR) over all NUM_PAGES pages sets every bit used.
// Output register holds one result; it waits while o_rsp.ready is low, and the
// next word is taken only after it is taken.
module bitmap_page_allocator_top #(
    parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data,
    bpa_req_if.sink     i_req,
    bpa_rsp_if.source   o_rsp
);
    localparam int PW = $clog2(NUM_PAGES + 1);
    localparam int IW = $clog2(NUM_PAGES);

    typedef enum logic [6:0] {
        S_CLR = 7'b0000001, S_IDLE = 7'b0000010, S_RD = 7'b0000100,
        S_CHK = 7'b0001000, S_FILL = 7'b0010000, S_OUT = 7'b0100000,
        S_WT = 7'b1000000
    } t_st;

    logic          mem [NUM_PAGES];
    logic          r_rd;
    logic [IW-1:0] mem_ra, mem_wa;
    logic          mem_we, mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    t_st          r_st;
    logic [12:0]  r_lim_cfg;
    logic [PW-1:0] r_i, r_end, r_start, r_run, r_cnt;
    logic [12:0]  r_want;
    logic [1:0]   r_req;
    logic         r_ok;
    logic [23:0]  r_ra;
    logic [24:0]  r_fb;

    // effective tracked count
    logic [PW+13:0] lim;
    always_comb begin
        lim = {{(PW+1){1'b0}}, r_lim_cfg};
        if (lim > NUM_PAGES) lim = (PW+14)'(NUM_PAGES);
        if (lim > bpa_pkg::ADDR_PAGES) lim = (PW+14)'(bpa_pkg::ADDR_PAGES);
    end
    wire [PW-1:0] limp = lim[PW-1:0];

    logic [25:0] mend;
    always_comb mend = 26'(i_req.address[23:12]) +
                       26'((27'(i_req.region_length) + 27'd4095) >> 12);

    assign i_req.ready = (r_st == S_IDLE);
    assign o_rsp.valid = (r_st == S_OUT);
    assign o_rsp.success = r_ok;
    assign o_rsp.run_address = r_ra;
    assign o_rsp.free_bytes = r_fb;

    assign mem_ra = r_i[IW-1:0];
    always_comb begin
        mem_we = 1'b0; mem_wa = r_i[IW-1:0]; mem_wd = 1'b1;
        case (r_st)
            S_CLR:  mem_we = 1'b1;
            S_FILL: mem_we = 1'b1;
            S_CHK: begin
                if (r_req == bpa_pkg::REQ_FREE && r_rd) begin
                    mem_we = 1'b1; mem_wd = 1'b0;
                end
            end
            S_RD: begin
                if (r_req == bpa_pkg::REQ_MARK) begin
                    mem_we = 1'b1; mem_wd = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_i <= '0; r_lim_cfg <= 13'd4096;
        end else begin
            if (i_cfg_we) r_lim_cfg <= i_cfg_data;
            case (r_st)
                S_CLR: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == PW'(NUM_PAGES - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (i_req.valid) begin
                    r_req <= i_req.req_type; r_want <= i_req.page_count;
                    r_ok <= (i_req.req_type != bpa_pkg::REQ_ALLOC);
                    r_ra <= '0; r_fb <= '0; r_run <= '0; r_cnt <= '0;
                    case (i_req.req_type)
                        bpa_pkg::REQ_MARK: begin
                            r_i <= PW'(i_req.address[23:12]);
                            r_end <= (mend > 26'(limp)) ? limp : mend[PW-1:0];
                            r_st <= (13'(i_req.address[23:12]) < 13'(limp) &&
                                     mend > 26'(i_req.address[23:12]) &&
                                     14'(i_req.address[23:12]) < 14'(limp)) ? S_RD : S_OUT;
                        end
                        bpa_pkg::REQ_FREE: begin
                            r_i <= PW'(i_req.address[23:12]);
                            r_st <= (14'(i_req.address[23:12]) < 14'(limp)) ? S_RD : S_OUT;
                        end
                        bpa_pkg::REQ_ALLOC: begin
                            r_i <= '0;
                            r_st <= (i_req.page_count != 0 && limp != 0) ? S_RD : S_OUT;
                        end
                        default: begin
                            r_i <= '0;
                            r_st <= (limp != 0) ? S_RD : S_OUT;
                        end
                    endcase
                end
                S_RD: begin
                    if (r_req == bpa_pkg::REQ_MARK) begin
                        r_i <= r_i + 1'b1;
                        if (r_i + 1'b1 >= r_end) r_st <= S_OUT;
                    end else r_st <= S_CHK;
                end
                S_CHK: begin
                    case (r_req)
                        bpa_pkg::REQ_FREE: begin
                            r_st <= (!r_rd || r_i + 1'b1 >= limp) ? S_OUT : S_RD;
                            r_i <= r_i + 1'b1;
                        end
                        bpa_pkg::REQ_QUERY: begin
                            if (!r_rd) r_cnt <= r_cnt + 1'b1;
                            if (r_i + 1'b1 >= limp) begin
                                r_st <= S_OUT;
                                r_fb <= 25'(r_cnt + PW'(!r_rd)) << 12;
                            end else r_st <= S_RD;
                            r_i <= r_i + 1'b1;
                        end
                        default: begin
                            if (!r_rd) begin
                                if (r_run == 0) r_start <= r_i;
                                r_run <= r_run + 1'b1;
                                if (14'(r_run) + 14'd1 == 14'(r_want)) begin
                                    r_ok <= 1'b1;
                                    r_ra <= 24'((r_run == 0 ? r_i : r_start)) << 12;
                                    r_i <= (r_run == 0) ? r_i : r_start;
                                    r_st <= S_FILL;
                                end else begin
                                    r_i <= r_i + 1'b1;
                                    r_st <= (r_i + 1'b1 >= limp) ? S_OUT : S_RD;
                                end
                            end else begin
                                r_run <= '0; r_i <= r_i + 1'b1;
                                r_st <= (r_i + 1'b1 >= limp) ? S_OUT : S_RD;
                            end
                        end
                    endcase
                end
                // r_run counts the pages of the run still to be marked used
                S_FILL: begin
                    r_i <= r_i + 1'b1; r_run <= r_run - 1'b1;
                    if (r_run == PW'(1)) r_st <= S_OUT;
                end
                S_OUT: if (o_rsp.ready) r_st <= S_WT;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

/* design/bpa_checker.sv */
module bpa_checker (
    input logic i_clk, input logic i_rst_n,
    input logic iv, input logic ir, input logic ov, input logic orr,
    input logic os, input logic [23:0] ora, input logic [24:0] ofb
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(ir && ov))
        else $error("ready with pending result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ov && !orr |=> ov && $stable(ora)) else $error("result dropped");
    a_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ov && !os |-> ora == 24'd0) else $error("failed alloc with address");
    a_pg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ov |-> ora[11:0] == 12'd0 && ofb[11:0] == 12'd0) else $error("not page aligned");
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iv && !ir |=> iv) else $error("request withdrawn");
endmodule

bind bitmap_page_allocator_top bpa_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .iv(i_req.valid), .ir(i_req.ready),
    .ov(o_rsp.valid), .orr(o_rsp.ready), .os(o_rsp.success),
    .ora(o_rsp.run_address), .ofb(o_rsp.free_bytes));

/* tb/sv/bitmap_page_allocator_top_tb.sv */
module bitmap_page_allocator_top_tb;

    localparam int TB_PAGES    = 4096;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct packed {
        bpa_pkg::t_req kind;
        logic [23:0]   addr;
        logic [24:0]   len;
        logic [12:0]   cnt;
    } t_req_word;

    typedef struct packed {
        logic        ok;
        logic [23:0] run;
        logic [24:0] freeb;
    } t_rsp_word;

    // bitmap mirror plus queue of expected response words
    class alloc_scoreboard;
        bit          used_map [TB_PAGES];
        int unsigned page_lim;
        t_rsp_word   expected_q [$];
        logic [23:0] alloc_starts [$];
        int          mismatches;

        function new();
            foreach (used_map[i]) used_map[i] = 1'b1;
            page_lim   = 4096;
            mismatches = 0;
        endfunction

        function int unsigned tracked();
            int unsigned n;
            n = page_lim;
            if (n > TB_PAGES) n = TB_PAGES;
            return n;
        endfunction

        // work out the response to one accepted request word
        function void note_request(t_req_word r);
            t_rsp_word   e;
            int unsigned lim, first, stop, run, start, cnt;
            lim = tracked();
            e   = '{ok: 1'b1, run: '0, freeb: '0};
            case (r.kind)
                bpa_pkg::REQ_MARK: begin
                    first = r.addr >> 12;
                    stop  = first + ((int'(r.len) + 4095) >> 12);
                    if (stop > lim) stop = lim;
                    for (int unsigned i = first; i < stop; i++) used_map[i] = 1'b0;
                end
                bpa_pkg::REQ_ALLOC: begin
                    e.ok  = 1'b0;
                    run   = 0;
                    start = 0;
                    if (r.cnt != 0) begin
                        for (int unsigned i = 0; i < lim; i++) begin
                            if (!used_map[i]) begin
                                if (run == 0) start = i;
                                run++;
                                if (run == r.cnt) begin
                                    for (int unsigned j = start; j < start + r.cnt; j++)
                                        used_map[j] = 1'b1;
                                    e.ok  = 1'b1;
                                    e.run = 24'(start << 12);
                                    alloc_starts.push_back(e.run);
                                    break;
                                end
                            end else begin
                                run = 0;
                            end
                        end
                    end
                end
                bpa_pkg::REQ_FREE: begin
                    for (int unsigned i = r.addr >> 12; i < lim && used_map[i]; i++)
                        used_map[i] = 1'b0;
                end
                default: begin
                    cnt = 0;
                    for (int unsigned i = 0; i < lim; i++) if (!used_map[i]) cnt++;
                    e.freeb = 25'(cnt << 12);
                end
            endcase
            expected_q.push_back(e);
        endfunction

        function void check_response(t_rsp_word got);
            t_rsp_word e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: ok=%0b run=%h free=%h",
                             got.ok, got.run, got.freeb);
                return;
            end
            e = expected_q.pop_front();
            if (e != got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"response mismatch: exp ok=%0b run=%h free=%h, ",
                              "got ok=%0b run=%h free=%h"},
                             e.ok, e.run, e.freeb, got.ok, got.run, got.freeb);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [12:0] i_cfg_data = '0;
    bit          calm = 1'b0;
    int unsigned cycles = 0;

    bpa_req_if req_if ();
    bpa_rsp_if rsp_if ();

    alloc_scoreboard sb = new();

    bitmap_page_allocator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        req_if.valid         = 1'b0;
        req_if.req_type      = bpa_pkg::REQ_QUERY;
        req_if.address       = '0;
        req_if.region_length = '0;
        req_if.page_count    = '0;
        rsp_if.ready         = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // response ready with random stall bursts
    initial begin : rsp_ready_drv
        int burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n || calm) begin
                rsp_if.ready <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                rsp_if.ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 4);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_response('{ok: rsp_if.success, run: rsp_if.run_address,
                                freeb: rsp_if.free_bytes});
    end

    // one request word, with a random gap ahead of it
    task automatic send_word(t_req_word r);
        int gap;
        gap = (calm || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 5);
        repeat (gap) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_if.valid         <= 1'b1;
        req_if.req_type      <= r.kind;
        req_if.address       <= r.addr;
        req_if.region_length <= r.len;
        req_if.page_count    <= r.cnt;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(r);
    endtask

    task automatic send_req(bpa_pkg::t_req k, int unsigned a, int unsigned l,
                            int unsigned c);
        send_word('{kind: k, addr: 24'(a), len: 25'(l), cnt: 13'(c)});
    endtask

    // drain, settle, then write the page limit
    task automatic set_page_limit(int unsigned v);
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= 13'(v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.page_lim = v;
    endtask

    function automatic t_req_word random_word(int unsigned lim);
        t_req_word   r;
        int unsigned p;
        p      = $urandom_range(0, 99);
        r.addr = 24'(($urandom_range(0, lim + 2) << 12) | $urandom_range(0, 4095));
        r.len  = 25'($urandom_range(0, 8 * 4096));
        r.cnt  = 13'($urandom_range(1, 8));
        if (p < 25) begin
            r.kind = bpa_pkg::REQ_MARK;
            if ($urandom_range(0, 19) == 0) begin
                r.addr = 24'($urandom);
                r.len  = 25'($urandom_range(0, 16777216));
            end else if ($urandom_range(0, 29) == 0) begin
                r.len = 25'd16777216;
            end
        end else if (p < 55) begin
            r.kind = bpa_pkg::REQ_ALLOC;
            if ($urandom_range(0, 9) == 0) r.cnt = 13'($urandom);
            else if ($urandom_range(0, 19) == 0) r.cnt = '0;
        end else if (p < 80) begin
            r.kind = bpa_pkg::REQ_FREE;
            if (sb.alloc_starts.size() > 0 && $urandom_range(0, 3) != 0)
                r.addr = sb.alloc_starts[$urandom_range(0, sb.alloc_starts.size() - 1)]
                         | 24'($urandom_range(0, 4095));
            else if ($urandom_range(0, 9) == 0)
                r.addr = 24'($urandom);
        end else begin
            r.kind = bpa_pkg::REQ_QUERY;
            r.addr = 24'($urandom);
            r.len  = 25'($urandom);
            r.cnt  = 13'($urandom);
        end
        return r;
    endfunction

    initial begin : stimulus
        int unsigned lim;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full bitmap: edges of every request type
        send_req(bpa_pkg::REQ_QUERY, 0, 0, 0);
        send_req(bpa_pkg::REQ_MARK, 0, 0, 0);                     // zero length
        send_req(bpa_pkg::REQ_MARK, 0, 1, 0);                     // partial page
        send_req(bpa_pkg::REQ_MARK, 24'hFFF000, 25'h1000000, 0);  // runs past the top
        send_req(bpa_pkg::REQ_MARK, 10 * 4096 + 7, 100 * 4096, 0);
        send_req(bpa_pkg::REQ_ALLOC, 0, 0, 0);                    // zero pages
        send_req(bpa_pkg::REQ_ALLOC, 0, 0, 4096);                 // too many
        send_req(bpa_pkg::REQ_ALLOC, 0, 0, 13'h1FFF);
        send_req(bpa_pkg::REQ_ALLOC, 0, 0, 1);
        send_req(bpa_pkg::REQ_ALLOC, 0, 0, 50);
        send_req(bpa_pkg::REQ_FREE, 24'hFFFFFF, 0, 0);            // top page
        send_req(bpa_pkg::REQ_FREE, 200 * 4096, 0, 0);            // used page: frees every page up to the free top page
        send_req(bpa_pkg::REQ_FREE, 12 * 4096 + 123, 0, 0);       // mid run, truncated
        send_req(bpa_pkg::REQ_QUERY, 24'hFFFFFF, 25'h1FFFFFF, 13'h1FFF);

        // no pages tracked
        set_page_limit(0);
        send_req(bpa_pkg::REQ_ALLOC, 0, 0, 1);
        send_req(bpa_pkg::REQ_MARK, 0, 8192, 0);
        send_req(bpa_pkg::REQ_FREE, 0, 0, 0);
        send_req(bpa_pkg::REQ_QUERY, 0, 0, 0);

        // one page tracked
        set_page_limit(1);
        send_req(bpa_pkg::REQ_MARK, 0, 4096, 0);
        send_req(bpa_pkg::REQ_ALLOC, 0, 0, 2);
        send_req(bpa_pkg::REQ_ALLOC, 0, 0, 1);
        send_req(bpa_pkg::REQ_QUERY, 0, 0, 0);
        send_req(bpa_pkg::REQ_FREE, 4096, 0, 0);                  // beyond tracked count

        // random phases over small bitmaps, last phase without idling
        for (int ph = 0; ph < 6; ph++) begin
            lim = (ph == 0) ? 2 : $urandom_range(1, 64);
            set_page_limit(lim);
            if (ph == 5) calm = 1'b1;
            repeat (220) send_word(random_word(lim));
        end

        // back to the full size for a short stretch
        set_page_limit(4096);
        repeat (12) send_word(random_word(4096));

        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
